FILE: hw/rtl/rmd_pkg.sv
`default_nettype none

package rmd_pkg;

    localparam int HEADER_BYTES = 20;
    localparam int HDR_CNT_W    = 5;

    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] KIND_BODY   = 2'd0;
    localparam logic [1:0] KIND_MARKER = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [2:0] ST_ACCEPTED    = 3'd0;
    localparam logic [2:0] ST_TOO_SHORT   = 3'd1;
    localparam logic [2:0] ST_BAD_MAGIC   = 3'd2;
    localparam logic [2:0] ST_BAD_VERSION = 3'd3;
    localparam logic [2:0] ST_TRUNCATED   = 3'd4;

    localparam logic [1:0] REJ_NONE    = 2'd0;
    localparam logic [1:0] REJ_MAGIC   = 2'd1;
    localparam logic [1:0] REJ_VERSION = 2'd2;

    localparam logic       REG_VERSION_MAJOR   = 1'b0;
    localparam logic       REG_VERSION_MINOR   = 1'b1;
    localparam logic [7:0] VERSION_MAJOR_RESET = 8'd2;
    localparam logic [7:0] VERSION_MINOR_RESET = 8'd4;

    typedef struct packed {
        logic [7:0] major;
        logic [7:0] minor;
    } t_cfg;

    // One queue entry: an optional body/marker result and an optional status
    typedef struct packed {
        logic        has_item;
        logic [1:0]  item_kind;
        logic [7:0]  sub_id;
        logic [7:0]  sub_flags;
        logic [7:0]  body_byte;
        logic [15:0] body_offset;
        logic        body_end;
        logic        has_status;
        logic [2:0]  status;
    } t_cmd;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd0:    v = 8'h52; // R
            2'd1:    v = 8'h54; // T
            2'd2:    v = 8'h50; // P
            default: v = 8'h53; // S
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rtps_message_deframer_unit.sv
// RTPS message deframer.
// Input channel: one message byte per transaction on i_data_byte, with
// i_end_of_message set on the final byte; i_in_valid / o_in_stall.
// Output channel: result transactions on o_out_valid / i_out_stall. A body
// byte gives one result; the final byte of a message also gives a status
// result (kind 2), preceded by an empty-body marker (kind 1) when the last
// submessage header ends the message with a zero length. o_last_result marks
// the final result caused by an input byte.
// Path: an accepted byte's result is written into the queue and then
// registered in the output stage. Throughput: one byte per cycle while
// o_in_stall is low; a final byte that gives two results is absorbed by a
// four-entry queue between parser and output stage. o_in_stall rises only
// when that queue is full. Receiver stall: the output register holds its
// result, the queue fills, and the input stalls once it holds four entries.
// Reset (synchronous, i_rst_n low): parser back to the message header, queue
// and output emptied, version registers to major 2 / minor 4.
// Registers over APB: version_major at 0x0, version_minor at 0x4; write
// them only while the block is idle.
`default_nettype none

module rtps_message_deframer_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_end_of_message,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_sub_id,
    output logic [7:0]       o_sub_flags,
    output logic [7:0]       o_body_byte,
    output logic [15:0]      o_body_offset,
    output logic             o_body_end,
    output logic [2:0]       o_status,
    output logic             o_last_result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import rmd_pkg::*;

    t_cfg  r_cfg;
    t_cmd  push_cmd;
    t_cmd  head_cmd;
    logic  push;
    logic  pop;
    logic  q_empty;
    logic  q_full;
    logic  in_accept;
    logic  cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_VERSION_MINOR) ? {24'd0, r_cfg.minor}
                                                       : {24'd0, r_cfg.major};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.major <= VERSION_MAJOR_RESET;
            r_cfg.minor <= VERSION_MINOR_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == REG_VERSION_MAJOR)
                r_cfg.major <= pwdata[7:0];
            else
                r_cfg.minor <= pwdata[7:0];
        end
    end

    assign o_in_stall = q_full;

    rmd_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_data_byte      (i_data_byte),
        .i_end_of_message (i_end_of_message),
        .i_queue_full     (q_full),
        .i_cfg            (r_cfg),
        .o_accept         (in_accept),
        .o_push           (push),
        .o_cmd            (push_cmd)
    );

    rmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    rmd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (head_cmd),
        .i_empty       (q_empty),
        .i_out_stall   (i_out_stall),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .o_kind        (o_kind),
        .o_sub_id      (o_sub_id),
        .o_sub_flags   (o_sub_flags),
        .o_body_byte   (o_body_byte),
        .o_body_offset (o_body_offset),
        .o_body_end    (o_body_end),
        .o_status      (o_status),
        .o_last_result (o_last_result)
    );

    a_push_only_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> in_accept)
        else $error("queue push without an accepted byte");

    a_last_byte_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_end_of_message) |-> (push && push_cmd.has_status))
        else $error("final byte produced no status");

    a_stall_matches_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept |-> !q_full))
        else $error("byte accepted while queue full");

endmodule

`default_nettype wire

FILE: hw/rtl/rmd_front.sv
`default_nettype none

module rmd_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic [7:0]    i_data_byte,
    input  wire logic          i_end_of_message,
    input  wire logic          i_queue_full,
    input  rmd_pkg::t_cfg      i_cfg,
    output logic               o_accept,
    output logic               o_push,
    output rmd_pkg::t_cmd      o_cmd
);
    import rmd_pkg::*;

    typedef enum logic [1:0] {PH_HDR, PH_SUB, PH_BODY, PH_REJ} t_phase;

    t_phase               r_phase, n_phase;
    logic [HDR_CNT_W-1:0] r_byte_count, n_byte_count;
    logic [1:0]           r_reject, n_reject;
    logic [7:0]           r_cur_id, n_cur_id;
    logic [7:0]           r_cur_flags, n_cur_flags;
    logic [7:0]           r_len_low, n_len_low;
    logic [15:0]          r_body_rem, n_body_rem;
    logic [15:0]          r_body_pos, n_body_pos;
    logic                 r_runs_to_end, n_runs_to_end;

    logic [15:0] len;
    logic [2:0]  st;
    t_cmd        cmd;

    assign o_accept = i_in_valid && !i_queue_full;

    always_comb begin
        n_phase       = r_phase;
        n_byte_count  = r_byte_count;
        n_reject      = r_reject;
        n_cur_id      = r_cur_id;
        n_cur_flags   = r_cur_flags;
        n_len_low     = r_len_low;
        n_body_rem    = r_body_rem;
        n_body_pos    = r_body_pos;
        n_runs_to_end = r_runs_to_end;
        st            = ST_ACCEPTED;
        cmd           = '0;
        len = r_cur_flags[0] ? {i_data_byte, r_len_low} : {r_len_low, i_data_byte};

        case (r_phase)
            PH_HDR: begin
                if (r_byte_count < HDR_CNT_W'(4)) begin
                    if (i_data_byte != magic_byte(r_byte_count[1:0]) && r_reject == REJ_NONE)
                        n_reject = REJ_MAGIC;
                end else if (r_byte_count == HDR_CNT_W'(4)) begin
                    if (i_data_byte != i_cfg.major && r_reject == REJ_NONE)
                        n_reject = REJ_VERSION;
                end else if (r_byte_count == HDR_CNT_W'(5)) begin
                    if (i_data_byte > i_cfg.minor && r_reject == REJ_NONE)
                        n_reject = REJ_VERSION;
                end
                if (r_byte_count == HDR_CNT_W'(HEADER_BYTES - 1)) begin
                    n_byte_count = '0;
                    n_phase      = (n_reject != REJ_NONE) ? PH_REJ : PH_SUB;
                    st = (n_reject == REJ_MAGIC)   ? ST_BAD_MAGIC :
                         (n_reject == REJ_VERSION) ? ST_BAD_VERSION : ST_ACCEPTED;
                end else begin
                    n_byte_count = r_byte_count + HDR_CNT_W'(1);
                    st           = ST_TOO_SHORT;
                end
            end
            PH_SUB: begin
                case (r_byte_count[1:0])
                    2'd0: begin
                        n_cur_id     = i_data_byte;
                        n_byte_count = HDR_CNT_W'(1);
                    end
                    2'd1: begin
                        n_cur_flags  = i_data_byte;
                        n_byte_count = HDR_CNT_W'(2);
                    end
                    2'd2: begin
                        n_len_low    = i_data_byte;
                        n_byte_count = HDR_CNT_W'(3);
                    end
                    default: begin
                        n_byte_count  = '0;
                        n_phase       = PH_BODY;
                        n_body_pos    = '0;
                        n_body_rem    = len;
                        n_runs_to_end = (len == 16'd0);
                        if (i_end_of_message) begin
                            if (len == 16'd0) begin
                                cmd.has_item  = 1'b1;
                                cmd.item_kind = KIND_MARKER;
                                cmd.sub_id    = r_cur_id;
                                cmd.sub_flags = r_cur_flags;
                                cmd.body_end  = 1'b1;
                            end else begin
                                st = ST_TRUNCATED;
                            end
                        end
                    end
                endcase
            end
            PH_BODY: begin
                cmd.has_item    = 1'b1;
                cmd.item_kind   = KIND_BODY;
                cmd.sub_id      = r_cur_id;
                cmd.sub_flags   = r_cur_flags;
                cmd.body_byte   = i_data_byte;
                cmd.body_offset = r_body_pos;
                cmd.body_end    = r_runs_to_end ? i_end_of_message : (r_body_rem == 16'd1);
                // saturate in an open-ended body
                if (r_body_pos != 16'hFFFF)
                    n_body_pos = r_body_pos + 16'd1;
                if (!r_runs_to_end) begin
                    n_body_rem = r_body_rem - 16'd1;
                    if (r_body_rem == 16'd1) begin
                        n_phase      = PH_SUB;
                        n_byte_count = '0;
                    end else if (i_end_of_message) begin
                        st = ST_TRUNCATED;
                    end
                end
            end
            PH_REJ: begin
                st = (r_reject == REJ_MAGIC) ? ST_BAD_MAGIC : ST_BAD_VERSION;
            end
            default: begin
                n_phase = PH_HDR;
            end
        endcase

        if (i_end_of_message) begin
            cmd.has_status = 1'b1;
            cmd.status     = st;
            n_phase        = PH_HDR;
            n_byte_count   = '0;
            n_reject       = REJ_NONE;
            n_cur_id       = '0;
            n_cur_flags    = '0;
            n_len_low      = '0;
            n_body_rem     = '0;
            n_body_pos     = '0;
            n_runs_to_end  = 1'b0;
        end
    end

    assign o_push = o_accept && (cmd.has_item || cmd.has_status);
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HDR;
            r_byte_count  <= '0;
            r_reject      <= REJ_NONE;
            r_cur_id      <= '0;
            r_cur_flags   <= '0;
            r_len_low     <= '0;
            r_body_rem    <= '0;
            r_body_pos    <= '0;
            r_runs_to_end <= 1'b0;
        end else if (o_accept) begin
            r_phase       <= n_phase;
            r_byte_count  <= n_byte_count;
            r_reject      <= n_reject;
            r_cur_id      <= n_cur_id;
            r_cur_flags   <= n_cur_flags;
            r_len_low     <= n_len_low;
            r_body_rem    <= n_body_rem;
            r_body_pos    <= n_body_pos;
            r_runs_to_end <= n_runs_to_end;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/rmd_queue.sv
`default_nettype none

module rmd_queue (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  rmd_pkg::t_cmd  i_cmd,
    input  wire logic      i_pop,
    output rmd_pkg::t_cmd  o_cmd,
    output logic           o_empty,
    output logic           o_full
);
    import rmd_pkg::*;

    t_cmd                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_PTR_W:0]   r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push)
                r_wr_ptr <= r_wr_ptr + QUEUE_PTR_W'(1);
            if (i_pop)
                r_rd_ptr <= r_rd_ptr + QUEUE_PTR_W'(1);
            if (i_push && !i_pop)
                r_count <= r_count + (QUEUE_PTR_W+1)'(1);
            else if (!i_push && i_pop)
                r_count <= r_count - (QUEUE_PTR_W+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wr_ptr] <= i_cmd;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("queue read while empty");

endmodule

`default_nettype wire

FILE: hw/rtl/rmd_back.sv
`default_nettype none

module rmd_back (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  rmd_pkg::t_cmd     i_cmd,
    input  wire logic         i_empty,
    input  wire logic         i_out_stall,
    output logic              o_pop,
    output logic              o_out_valid,
    output logic [1:0]        o_kind,
    output logic [7:0]        o_sub_id,
    output logic [7:0]        o_sub_flags,
    output logic [7:0]        o_body_byte,
    output logic [15:0]       o_body_offset,
    output logic              o_body_end,
    output logic [2:0]        o_status,
    output logic              o_last_result
);
    import rmd_pkg::*;

    logic r_out_valid;
    logic r_item_done;
    logic load;
    logic take;
    logic emit_item;

    assign load      = !r_out_valid || !i_out_stall;
    assign take      = load && !i_empty;
    assign emit_item = i_cmd.has_item && !r_item_done;
    // hold the entry at the head until its status has gone out too
    assign o_pop     = take && !(emit_item && i_cmd.has_status);

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_item_done <= 1'b0;
        end else if (load) begin
            r_out_valid <= !i_empty;
            if (take)
                r_item_done <= emit_item && i_cmd.has_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            if (emit_item) begin
                o_kind        <= i_cmd.item_kind;
                o_sub_id      <= i_cmd.sub_id;
                o_sub_flags   <= i_cmd.sub_flags;
                o_body_byte   <= i_cmd.body_byte;
                o_body_offset <= i_cmd.body_offset;
                o_body_end    <= i_cmd.body_end;
                o_status      <= ST_ACCEPTED;
                o_last_result <= !i_cmd.has_status;
            end else begin
                o_kind        <= KIND_STATUS;
                o_sub_id      <= '0;
                o_sub_flags   <= '0;
                o_body_byte   <= '0;
                o_body_offset <= '0;
                o_body_end    <= 1'b0;
                o_status      <= i_cmd.status;
                o_last_result <= 1'b1;
            end
        end
    end

    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_kind == KIND_STATUS) |-> o_last_result)
        else $error("status result not marked last");

    a_marker_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_kind == KIND_MARKER) |-> (o_body_end && !o_last_result))
        else $error("empty-body marker malformed");

    a_marker_then_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_stall && o_kind == KIND_MARKER)
            |=> (r_out_valid && o_kind == KIND_STATUS))
        else $error("empty-body marker not followed by status");

endmodule

`default_nettype wire
